[hdl/xsr_pkg.sv]
// Package for the ranged xorshift64* generator: constants, codes and control types.
`timescale 1ns / 1ps
package xsr_pkg;

  localparam logic [63:0] MULTIPLIER = 64'd2685821657736338717;
  localparam int unsigned SHIFT_A    = 12;
  localparam int unsigned SHIFT_B    = 25;
  localparam int unsigned SHIFT_C    = 27;

  // two dividend bits consumed per divider step
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [1:0] REQ_RAW     = 2'd0;
  localparam logic [1:0] REQ_RANGE   = 2'd1;
  localparam logic [1:0] REQ_UNIFORM = 2'd2;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL,
    MUL_UNI
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic is_range;
    logic is_uniform;
    logic bad;
    logic out_free;
  } status_t;

endpackage

[hdl/xsr_ctrl.sv]
// Sequencer for the ranged xorshift64* generator.
`timescale 1ns / 1ps
module xsr_ctrl
  import xsr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_UMUL,
    S_LOAD
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_LL;
    unique case (state_q)
      S_IDLE: cmd_o.accept = in_valid_i;
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LL;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LH;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HL;
      end
      S_DIV:  cmd_o.div_step = 1'b1;
      S_UMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_UNI;
      end
      S_LOAD: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_MUL0;
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: begin
          cnt_q <= '0;
          if (status_i.bad) begin
            state_q <= S_LOAD;
          end else if (status_i.is_range) begin
            state_q <= S_DIV;
          end else if (status_i.is_uniform) begin
            state_q <= S_UMUL;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_LOAD;
        end
        S_UMUL: state_q <= S_LOAD;
        S_LOAD: if (status_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/xsr_datapath.sv]
// Datapath: generator state, shared 32x32 multiplier, radix-4 remainder unit, result register.
`timescale 1ns / 1ps
module xsr_datapath
  import xsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] range_min_i,
  input  logic signed [31:0] range_max_i,
  output logic [63:0]        raw_draw_o,
  output logic signed [31:0] scaled_value_o,
  output logic               bad_range_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cmd_t               cmd_i,
  output status_t            status_o
);

  logic [63:0] state_q;
  logic [63:0] draw_q;
  logic [31:0] hi_acc_q;
  logic [63:0] dsh_q;
  logic [31:0] rem_q;
  logic [31:0] span_q;
  logic [31:0] lo_q;
  logic        bad_q;
  logic        is_range_q;
  logic        is_uni_q;
  logic        out_valid_q;

  logic [63:0] x1, x2, x3;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] draw_hi;
  logic [32:0] span_w;
  logic [32:0] r1, r2;
  logic [31:0] r1m, r2m;

  always_comb begin
    x1 = state_q ^ (state_q >> SHIFT_A);
    x2 = x1 ^ (x1 << SHIFT_B);
    x3 = x2 ^ (x2 >> SHIFT_C);
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LL: begin
        mul_a = state_q[31:0];
        mul_b = MULTIPLIER[31:0];
      end
      MUL_LH: begin
        mul_a = state_q[31:0];
        mul_b = MULTIPLIER[63:32];
      end
      MUL_HL: begin
        mul_a = state_q[63:32];
        mul_b = MULTIPLIER[31:0];
      end
      default: begin
        mul_a = draw_q[63:32];
        mul_b = span_q;
      end
    endcase
    prod    = {32'd0, mul_a} * {32'd0, mul_b};
    draw_hi = hi_acc_q + prod[31:0];
  end

  assign span_w = {range_max_i[31], range_max_i} - {range_min_i[31], range_min_i};

  // two restoring steps per cycle; remainder stays below span
  always_comb begin
    r1  = {rem_q, dsh_q[63]};
    r1m = (r1 >= {1'b0, span_q}) ? 32'(r1 - {1'b0, span_q}) : r1[31:0];
    r2  = {r1m, dsh_q[62]};
    r2m = (r2 >= {1'b0, span_q}) ? 32'(r2 - {1'b0, span_q}) : r2[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        state_q <= cfg_wdata_i;
      end else if (cmd_i.accept) begin
        state_q <= x3;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lo_q       <= range_min_i;
      span_q     <= span_w[31:0];
      bad_q      <= (range_max_i <= range_min_i);
      is_range_q <= (req_type_i == REQ_RANGE);
      is_uni_q   <= (req_type_i == REQ_UNIFORM);
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_LL: begin
          draw_q[31:0] <= prod[31:0];
          hi_acc_q     <= prod[63:32];
        end
        MUL_LH: hi_acc_q <= draw_hi;
        MUL_HL: begin
          draw_q[63:32] <= draw_hi;
          dsh_q         <= {draw_hi, draw_q[31:0]};
          rem_q         <= '0;
        end
        default: rem_q <= prod[63:32];
      endcase
    end
    if (cmd_i.div_step) begin
      rem_q <= r2m;
      dsh_q <= {dsh_q[61:0], 2'b00};
    end
    if (cmd_i.out_load) begin
      raw_draw_o <= draw_q;
      if (is_range_q || is_uni_q) begin
        bad_range_o    <= bad_q;
        scaled_value_o <= bad_q ? lo_q : lo_q + rem_q;
      end else begin
        bad_range_o    <= 1'b0;
        scaled_value_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.is_range   = is_range_q;
    status_o.is_uniform = is_uni_q;
    status_o.bad        = bad_q && (is_range_q || is_uni_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

[hdl/xorshift64_star_ranged_rng_unit.sv]
// Ranged xorshift64* generator: top level joining sequencer and datapath.
// Sequence from input acceptance to result valid: the shared 32x32 multiplier forms
// the draw in three passes; an integer range then runs the radix-4 remainder unit for
// 32 steps, a uniform request takes a fourth pass, and a raw or bad-range beat loads.
// One beat in flight: the next is accepted after load, and load waits for a free output.
// Reset clears the generator state to zero and drops the result valid.
`timescale 1ns / 1ps
module xorshift64_star_ranged_rng_unit
  import xsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] range_min_i,
  input  logic signed [31:0] range_max_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        raw_draw_o,
  output logic signed [31:0] scaled_value_o,
  output logic               bad_range_o
);

  cmd_t    cmd;
  status_t status;

  xsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xsr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .range_min_i    (range_min_i),
    .range_max_i    (range_max_i),
    .raw_draw_o     (raw_draw_o),
    .scaled_value_o (scaled_value_o),
    .bad_range_o    (bad_range_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule
